/* rtl/core/fct_pkg.sv */
`default_nettype none

package fct_pkg;

  // Plane store and number format
  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  // Product and accumulator widths
  localparam int PROD_W = 2 * COORD_W;           // coefficient times coordinate
  localparam int ABS_W  = COORD_W + 2;           // |a| + |b| + |c|
  localparam int EXT_W  = COORD_W - 1;           // extent
  localparam int PE_W   = EXT_W + ABS_W;         // extent times slack factor
  localparam int DT_W   = COORD_W + FRAC_BITS;   // d scaled to Q32.32
  localparam int ACC_W  = 2 * COORD_W + 4;       // exact signed distance

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_SPHERE = 2'd2;
  localparam logic [1:0] KIND_CUBE   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
  } plane_t;

endpackage

`default_nettype wire

/* rtl/core/frustum_containment_test_core.sv */
`default_nettype none

// Frustum containment test. Holds NUM_PLANES inward-facing clip planes
// (a, b, c, d in signed Q16.16) and tests a point, a sphere or an axis-aligned
// cube against all of them. Raise start with an item while busy is low; the
// beat is taken at that clock edge. A load beat (kind 0) writes one plane in
// that same edge, never raises busy and produces no result; a plane index at
// or beyond NUM_PLANES is dropped. A query beat raises busy, and once the
// last plane has passed the memory read, product and sum registers, done
// is high for one cycle with inside_res; busy falls in that same cycle, so
// the next beat may be started there. While a query is in flight no beat
// is taken; the plane memory delivers one plane per cycle
// and each plane then passes a multiply stage and a sum stage before its
// sign is folded into the answer. There is no output stall: done is a
// one-cycle strobe and the result must be captured when it is seen.
// Distances are exact at full width, so no input pattern saturates. Planes
// never loaded since reset read as zero: point and cube queries then fail,
// and a sphere query fails only for a zero extent. For the cube, the best
// corner of a plane is center distance plus extent * (|a| + |b| + |c|), so one
// sum per plane covers all eight corners; |a| + |b| + |c| is formed when the
// plane is loaded and kept in a second memory beside the coefficients.

module frustum_containment_test_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output      logic                    busy,
  input  wire logic [1:0]              kind,
  input  wire logic [2:0]              plane_index,
  input  wire fct_pkg::coord_t         coef_a,
  input  wire fct_pkg::coord_t         coef_b,
  input  wire fct_pkg::coord_t         coef_c,
  input  wire fct_pkg::coord_t         coef_d,
  input  wire fct_pkg::coord_t         pos_x,
  input  wire fct_pkg::coord_t         pos_y,
  input  wire fct_pkg::coord_t         pos_z,
  input  wire logic [fct_pkg::EXT_W-1:0] extent,
  output      logic                    done,
  output      logic                    inside_res
);

  import fct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t state;

  // Accept and load decode
  logic              accept;
  logic              load_wr;
  logic              query_go;
  logic [PIDX_W-1:0] wr_idx;

  assign accept   = start && !busy;
  assign load_wr  = accept && (kind == KIND_LOAD) && (int'(plane_index) < NUM_PLANES);
  assign query_go = accept && (kind != KIND_LOAD);
  assign wr_idx   = PIDX_W'(plane_index);

  // Latched query
  coord_t           qx;
  coord_t           qy;
  coord_t           qz;
  logic [EXT_W-1:0] qe;
  logic [1:0]       qkind;

  always_ff @(posedge clk) begin
    if (query_go) begin
      qx    <= pos_x;
      qy    <= pos_y;
      qz    <= pos_z;
      qe    <= extent;
      qkind <= kind;
    end
  end

  // Cube slack factor of the plane being loaded
  logic [COORD_W-1:0] ld_abs_a;
  logic [COORD_W-1:0] ld_abs_b;
  logic [COORD_W-1:0] ld_abs_c;
  logic [ABS_W-1:0]   ld_abs_sum;

  assign ld_abs_a   = coef_a[COORD_W-1] ? (~coef_a + 1'b1) : coef_a;
  assign ld_abs_b   = coef_b[COORD_W-1] ? (~coef_b + 1'b1) : coef_b;
  assign ld_abs_c   = coef_c[COORD_W-1] ? (~coef_c + 1'b1) : coef_c;
  assign ld_abs_sum = ABS_W'(ld_abs_a) + ABS_W'(ld_abs_b) + ABS_W'(ld_abs_c);

  // Plane memory: one word per plane, registered read
  plane_t            mem [NUM_PLANES];
  plane_t            mem_q;
  logic [ABS_W-1:0]  abs_mem [NUM_PLANES];
  logic [ABS_W-1:0]  abs_q;
  logic [NUM_PLANES-1:0] plane_vld;
  logic              vld_q;
  logic [PIDX_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem[wr_idx]     <= '{a: coef_a, b: coef_b, c: coef_c, d: coef_d};
      abs_mem[wr_idx] <= ld_abs_sum;
    end
    mem_q <= mem[rd_addr];
    abs_q <= abs_mem[rd_addr];
  end

  // Planes not written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_vld <= '0;
      vld_q     <= 1'b0;
    end else begin
      if (load_wr) begin
        plane_vld[wr_idx] <= 1'b1;
      end
      vld_q <= plane_vld[rd_addr];
    end
  end

  // Pipeline tags: read issued, plane out of memory, products, sum
  logic s0_vld;
  logic s0_last;
  logic s1_vld;
  logic s1_last;
  logic s2_vld;
  logic s2_last;
  logic s3_vld;
  logic s3_last;

  assign s0_vld  = (state == ST_ISSUE);
  assign s0_last = (rd_addr == PIDX_W'(NUM_PLANES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s1_last <= 1'b0;
      s2_vld  <= 1'b0;
      s2_last <= 1'b0;
      s3_vld  <= 1'b0;
      s3_last <= 1'b0;
    end else begin
      s1_vld  <= s0_vld;
      s1_last <= s0_vld && s0_last;
      s2_vld  <= s1_vld;
      s2_last <= s1_last;
      s3_vld  <= s2_vld;
      s3_last <= s2_last;
    end
  end

  // Stage 1: plane coefficients and the slack factor for sphere or cube
  plane_t           pl;
  logic [ABS_W-1:0] abs_sum;
  logic [ABS_W-1:0] slack_fac;

  assign pl      = vld_q ? mem_q : '0;
  assign abs_sum = vld_q ? abs_q : '0;

  always_comb begin
    case (qkind)
      KIND_SPHERE: slack_fac = ABS_W'(1) << FRAC_BITS;
      KIND_CUBE:   slack_fac = abs_sum;
      default:     slack_fac = '0;
    endcase
  end

  // Stage 2: products, registered
  logic signed [PROD_W-1:0] pa;
  logic signed [PROD_W-1:0] pb;
  logic signed [PROD_W-1:0] pc;
  logic signed [DT_W-1:0]   dterm;
  logic [PE_W-1:0]          pe;

  always_ff @(posedge clk) begin
    pa    <= pl.a * qx;
    pb    <= pl.b * qy;
    pc    <= pl.c * qz;
    dterm <= {pl.d, {FRAC_BITS{1'b0}}};
    pe    <= qe * slack_fac;
  end

  // Stage 3: exact distance, registered
  logic signed [ACC_W-1:0] dist_sum;

  always_ff @(posedge clk) begin
    dist_sum <= {{(ACC_W-PROD_W){pa[PROD_W-1]}}, pa}
              + {{(ACC_W-PROD_W){pb[PROD_W-1]}}, pb}
              + {{(ACC_W-PROD_W){pc[PROD_W-1]}}, pc}
              + {{(ACC_W-DT_W){dterm[DT_W-1]}}, dterm}
              + {{(ACC_W-PE_W){1'b0}}, pe};
  end

  logic dist_pos;
  assign dist_pos = !dist_sum[ACC_W-1] && (|dist_sum);

  // Sequencer, answer fold and result strobe
  logic inside_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= 1'b0;
      done       <= 1'b0;
      inside_res <= 1'b0;
      inside_acc <= 1'b0;
      rd_addr    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (query_go) begin
            busy       <= 1'b1;
            inside_acc <= 1'b1;
            rd_addr    <= '0;
            state      <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          // advance one plane per cycle
          if (s0_last) begin
            state <= ST_DRAIN;
          end else begin
            rd_addr <= rd_addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (s3_vld && s3_last) begin
            done       <= 1'b1;
            inside_res <= inside_acc && dist_pos;
            busy       <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
      // drop the answer on any failing plane
      if (s3_vld && !dist_pos) begin
        inside_acc <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/frustum_checker.sv */
`timescale 1ns / 100ps

module frustum_checker
  import fct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           kind,
  input  logic [2:0]           plane_index,
  input  coord_t               coef_a,
  input  coord_t               coef_b,
  input  coord_t               coef_c,
  input  coord_t               coef_d,
  input  coord_t               pos_x,
  input  coord_t               pos_y,
  input  coord_t               pos_z,
  input  logic [EXT_W-1:0]     extent,
  input  logic                 done,
  input  logic                 inside_res,
  output int                   n_errors,
  output int                   n_pending,
  output int                   n_checked,
  output int                   n_inside
);

  plane_t plane_shadow [NUM_PLANES];
  logic   inside_expected [$];

  initial begin
    n_errors  = 0;
    n_pending = 0;
    n_checked = 0;
    n_inside  = 0;
  end

  // Exact signed distance scaled to Q32.32.
  function automatic logic signed [127:0] plane_dist(plane_t pl,
                                                     logic signed [127:0] x,
                                                     logic signed [127:0] y,
                                                     logic signed [127:0] z);
    logic signed [127:0] sa, sb, sc, sd;
    sa = $signed(pl.a);
    sb = $signed(pl.b);
    sc = $signed(pl.c);
    sd = $signed(pl.d);
    return sa * x + sb * y + sc * z + sd * 65536;
  endfunction

  function automatic logic predict_inside(logic [1:0] k, coord_t x, coord_t y, coord_t z,
                                          logic [EXT_W-1:0] e);
    logic signed [127:0] ext_w, cx, cy, cz;
    logic pass, hit;
    pass  = 1'b1;
    ext_w = e;
    for (int p = 0; p < NUM_PLANES; p++) begin
      case (k)
        KIND_POINT: begin
          if (plane_dist(plane_shadow[p], x, y, z) <= 0) pass = 1'b0;
        end
        KIND_SPHERE: begin
          if (plane_dist(plane_shadow[p], x, y, z) + ext_w * 65536 <= 0) pass = 1'b0;
        end
        default: begin
          // cube: one corner with a positive distance keeps the plane
          hit = 1'b0;
          for (int n = 0; n < 8; n++) begin
            cx = n[0] ? x + ext_w : x - ext_w;
            cy = n[1] ? y + ext_w : y - ext_w;
            cz = n[2] ? z + ext_w : z - ext_w;
            if (plane_dist(plane_shadow[p], cx, cy, cz) > 0) hit = 1'b1;
          end
          if (!hit) pass = 1'b0;
        end
      endcase
    end
    return pass;
  endfunction

  task automatic flag_error(string msg);
    if (n_errors < 10) $display("[%0t] MISMATCH: %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) plane_shadow[p] = '0;
      inside_expected.delete();
    end else begin
      // retire the result first; a new beat can be taken in the same cycle
      if (done === 1'b1) begin
        if (inside_expected.size() == 0) begin
          flag_error($sformatf("result %0b with nothing outstanding", inside_res));
        end else begin
          want = inside_expected.pop_front();
          n_checked++;
          if (want) n_inside++;
          if (inside_res !== want)
            flag_error($sformatf("inside_res expected %0b, got %0b", want, inside_res));
        end
      end
      if (start && !busy) begin
        if (kind == KIND_LOAD) begin
          if (plane_index < NUM_PLANES)
            plane_shadow[plane_index] = '{a: coef_a, b: coef_b, c: coef_c, d: coef_d};
        end else begin
          inside_expected.push_back(predict_inside(kind, pos_x, pos_y, pos_z, extent));
        end
      end
    end
    n_pending = inside_expected.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import fct_pkg::*;

  localparam int ITEMS       = 1550;
  localparam int CYCLE_LIMIT = 400000;
  // idle time allowed after the last result retires
  localparam int DRAIN       = 2 * (NUM_PLANES + 4);
  localparam int ONE         = 65536;

  localparam coord_t           C_MAX   = 32'sh7FFF_FFFF;
  localparam coord_t           C_MIN   = 32'sh8000_0000;
  localparam coord_t           U       = 32'sh0001_0000;
  localparam logic [EXT_W-1:0] EXT_MAX = '1;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       kind;
  logic [2:0]       plane_index;
  coord_t           coef_a, coef_b, coef_c, coef_d;
  coord_t           pos_x, pos_y, pos_z;
  logic [EXT_W-1:0] extent;
  logic             done;
  logic             inside_res;

  int n_errors, n_pending, n_checked, n_inside;

  // stimulus bookkeeping
  int n_beats;           // beats that load a real plane or ask a query
  int n_dropped;         // loads aimed past the plane store
  int kind_count [4];
  int idle_pct;
  int unsigned cycles;

  frustum_containment_test_core uut (.*);

  frustum_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: stop a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Cycle limit of %0d reached with %0d results outstanding",
                 CYCLE_LIMIT, n_pending);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Random coordinate across the whole range, biased toward the extremes and toward zero.
  function automatic coord_t any_coord();
    case ($urandom_range(7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return coord_t'(int'($urandom_range(2)) - 1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [EXT_W-1:0] any_extent();
    case ($urandom_range(7))
      0:       return EXT_MAX;
      1:       return '0;
      default: return EXT_W'($urandom);
    endcase
  endfunction

  // Value within +/- span units; snap to a whole unit now and then so that
  // distances land exactly on zero more often.
  function automatic coord_t near_coord(int unsigned span);
    coord_t v;
    v = coord_t'($urandom_range(0, 2 * span * ONE)) - coord_t'(span * ONE);
    if ($urandom_range(3) == 0) v[15:0] = '0;
    return v;
  endfunction

  // Present one beat and hold it until the block takes it. Each cycle the
  // sender may idle (start low), so gaps land on every cycle of a query.
  // Entered and left at a falling edge.
  task automatic send_beat(logic [1:0] k, logic [2:0] idx,
                           coord_t a, coord_t b, coord_t c, coord_t d,
                           coord_t x, coord_t y, coord_t z, logic [EXT_W-1:0] e);
    logic offer, taken;
    // sender idles on 29 percent of offers, then 64, then never
    if (n_beats < ITEMS / 3)          idle_pct = 29;
    else if (n_beats < 2 * ITEMS / 3) idle_pct = 64;
    else                              idle_pct = 0;
    kind        <= k;
    plane_index <= idx;
    coef_a      <= a;
    coef_b      <= b;
    coef_c      <= c;
    coef_d      <= d;
    pos_x       <= x;
    pos_y       <= y;
    pos_z       <= z;
    extent      <= e;
    do begin
      offer = ($urandom_range(99) >= idle_pct);
      start <= offer;
      @(posedge clk);
      taken = offer && !busy;
      @(negedge clk);
    end while (!taken);
    kind_count[k]++;
    if (k == KIND_LOAD && idx >= NUM_PLANES) n_dropped++;
    else n_beats++;
  endtask

  // Load a plane; the query fields ride along as noise.
  task automatic load_plane(logic [2:0] idx, coord_t a, coord_t b, coord_t c, coord_t d);
    send_beat(KIND_LOAD, idx, a, b, c, d, any_coord(), any_coord(), any_coord(),
              any_extent());
  endtask

  // Ask a query; the plane fields ride along as noise.
  task automatic query(logic [1:0] k, coord_t x, coord_t y, coord_t z, logic [EXT_W-1:0] e);
    send_beat(k, 3'($urandom), any_coord(), any_coord(), any_coord(), any_coord(),
              x, y, z, e);
  endtask

  initial begin
    logic [1:0] qk;
    logic [EXT_W-1:0] ext2;

    // drive every input to a known value from time zero
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_LOAD;
    plane_index = '0;
    coef_a      = '0;
    coef_b      = '0;
    coef_c      = '0;
    coef_d      = '0;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    extent      = '0;
    n_beats     = 0;
    n_dropped   = 0;
    idle_pct    = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
    ext2 = EXT_W'(2 * ONE);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Planes never loaded read as zero: point and cube fail, sphere passes
    // only for a nonzero extent.
    query(KIND_POINT, any_coord(), any_coord(), any_coord(), any_extent());
    query(KIND_SPHERE, any_coord(), any_coord(), any_coord(), '0);
    query(KIND_SPHERE, any_coord(), any_coord(), any_coord(), EXT_W'(1));
    query(KIND_CUBE, any_coord(), any_coord(), any_coord(), EXT_MAX);

    // Extreme coefficients, plus loads past the store that must be dropped.
    load_plane(3'd0, C_MAX, C_MAX, C_MAX, C_MAX);
    load_plane(3'd5, C_MIN, C_MIN, C_MIN, C_MIN);
    load_plane(3'd6, C_MAX, C_MIN, C_MAX, C_MIN);
    load_plane(3'd7, C_MIN, C_MAX, C_MIN, C_MAX);

    // Widest products and sums the arithmetic can see.
    query(KIND_POINT, C_MIN, C_MIN, C_MIN, EXT_MAX);
    query(KIND_SPHERE, C_MAX, C_MAX, C_MAX, EXT_MAX);
    query(KIND_SPHERE, C_MIN, C_MIN, C_MIN, EXT_MAX);
    query(KIND_CUBE, C_MIN, C_MAX, C_MIN, EXT_MAX);

    // Axis-aligned box |x|, |y|, |z| < 10 units.
    load_plane(3'd0,  U,  '0, '0, 10 * U);
    load_plane(3'd1, -U,  '0, '0, 10 * U);
    load_plane(3'd2, '0,   U, '0, 10 * U);
    load_plane(3'd3, '0,  -U, '0, 10 * U);
    load_plane(3'd4, '0,  '0,  U, 10 * U);
    load_plane(3'd5, '0,  '0, -U, 10 * U);

    query(KIND_POINT, '0, '0, '0, '0);                     // center: inside
    query(KIND_POINT, 10 * U, '0, '0, '0);                 // on a face: out
    query(KIND_POINT, 10 * U - 1, '0, '0, '0);             // just inside
    query(KIND_SPHERE, 12 * U, '0, '0, ext2);              // touches: out
    query(KIND_SPHERE, 12 * U, '0, '0, ext2 + 1'b1);       // overlaps
    query(KIND_CUBE, 12 * U, '0, '0, ext2);                // face touches: out
    query(KIND_CUBE, 12 * U, '0, '0, EXT_W'(3 * ONE));     // overlaps

    // ---- random part ----
    // Mostly a fresh random frustum around the origin followed by queries
    // near it, so that results mix; the rest is full-range noise.
    while (n_beats < ITEMS) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if ($urandom_range(9) != 0)
          load_plane(3'(p), near_coord(1), near_coord(1), near_coord(1),
                     ($urandom_range(3) == 0) ? near_coord(20)
                                              : coord_t'($urandom_range(0, 30 * ONE)));
      end
      repeat ($urandom_range(8, 30)) begin
        if ($urandom_range(99) < 80) begin
          qk = 2'($urandom_range(KIND_POINT, KIND_CUBE));
          query(qk, near_coord(40), near_coord(40), near_coord(40),
                EXT_W'($urandom_range(0, 15 * ONE)));
        end else begin
          send_beat(2'($urandom), 3'($urandom), any_coord(), any_coord(), any_coord(),
                    any_coord(), any_coord(), any_coord(), any_coord(), any_extent());
        end
      end
    end

    // Drop start, let the last query retire, then allow a few idle cycles.
    start <= 1'b0;
    wait (n_pending == 0);
    repeat (DRAIN) @(posedge clk);

    $display("Drove %0d plane loads (%0d aimed past the store) and %0d point, %0d sphere, %0d cube queries.",
             kind_count[KIND_LOAD], n_dropped, kind_count[KIND_POINT],
             kind_count[KIND_SPHERE], kind_count[KIND_CUBE]);
    $display("Compared %0d results (%0d inside) with %0d mismatches.",
             n_checked, n_inside, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
